### rtl/pde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pde_pkg;

  localparam int DRIFT_FRAC_BITS = 30;
  localparam int TIMER_WIDTH     = 24;
  localparam int FLIP_W          = 24;
  localparam int DIV_W           = 64;
  localparam int DIV_CNT_W       = $clog2(DIV_W);
  localparam int ACC_W           = 50;
  localparam int PROD_W          = 49;

  localparam logic [31:0] DRIFT_ONE = 32'(64'd1 << DRIFT_FRAC_BITS);
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
  localparam logic [16:0] W_FULL     = 17'h10000;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  // register map, index = paddr[4:2]
  localparam logic [2:0] REG_PULSES_PER_SYNC = 3'd0;
  localparam logic [2:0] REG_SOURCE_PERIOD   = 3'd1;
  localparam logic [2:0] REG_FLIP_HALF       = 3'd2;
  localparam logic [2:0] REG_ALPHA           = 3'd3;
  localparam logic [2:0] REG_BETA            = 3'd4;

  localparam logic [7:0]  RST_PULSES_PER_SYNC = 8'd10;
  localparam logic [23:0] RST_SOURCE_PERIOD   = 24'd1000000;
  localparam logic [23:0] RST_FLIP_HALF       = 24'd500000;
  localparam logic [16:0] RST_ALPHA           = 17'd19661;
  localparam logic [16:0] RST_BETA            = 17'd13107;
  localparam logic [TIMER_WIDTH-1:0] RST_INTERVAL = TIMER_WIDTH'(500000);

  localparam logic KIND_PPS  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DEN,
    ST_INST_LD,
    ST_INST_DIV,
    ST_INST,
    ST_B1A,
    ST_B1B,
    ST_B1C,
    ST_B1D,
    ST_B2A,
    ST_B2B,
    ST_B2C,
    ST_B2D,
    ST_IV_LD,
    ST_IV_DIV,
    ST_IV_END,
    ST_EMIT
  } state_t;

  typedef enum logic {
    MUL_NEW,
    MUL_OLD
  } mul_sel_t;

  typedef enum logic {
    DIV_INST,
    DIV_IVAL
  } div_src_t;

  typedef struct packed {
    logic     load_item;
    logic     tick_step;
    logic     phase_adv;
    logic     sync_done;
    logic     den_mul;
    logic     div_load;
    div_src_t div_src;
    logic     div_step;
    logic     inst_load;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     w_beta;
    logic     acc_init;
    logic     acc_add;
    logic     smooth_load;
    logic     drift_load;
    logic     iv_load;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic sync;
    logic first_after_sync;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

### rtl/pde_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pde_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  pde_pkg::dp_status_t  status,
  output pde_pkg::dp_cmd_t     cmd
);
  import pde_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (status.is_tick) begin
          state_next = ST_EMIT;
        end else if (status.sync) begin
          state_next = ST_DEN;
        end else if (status.first_after_sync) begin
          state_next = ST_IV_LD;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_DEN:      state_next = ST_INST_LD;
      ST_INST_LD:  state_next = ST_INST_DIV;
      ST_INST_DIV: if (status.div_last) state_next = ST_INST;
      ST_INST:     state_next = ST_B1A;
      ST_B1A:      state_next = ST_B1B;
      ST_B1B:      state_next = ST_B1C;
      ST_B1C:      state_next = ST_B1D;
      ST_B1D:      state_next = ST_B2A;
      ST_B2A:      state_next = ST_B2B;
      ST_B2B:      state_next = ST_B2C;
      ST_B2C:      state_next = ST_B2D;
      ST_B2D:      state_next = ST_EMIT;
      ST_IV_LD:    state_next = ST_IV_DIV;
      ST_IV_DIV:   if (status.div_last) state_next = ST_IV_END;
      ST_IV_END:   state_next = ST_EMIT;
      ST_EMIT:     if (status.out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        // nothing is taken while reset is held
        in_ready      = !rst;
        cmd.load_item = in_valid && !rst;
      end
      ST_DECIDE: begin
        cmd.tick_step = status.is_tick;
        cmd.phase_adv = !status.is_tick && !status.sync;
      end
      ST_DEN: cmd.den_mul = 1'b1;
      ST_INST_LD: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DIV_INST;
      end
      ST_INST_DIV: cmd.div_step = 1'b1;
      ST_INST:     cmd.inst_load = 1'b1;
      ST_B1A: begin
        cmd.mul_go   = 1'b1;
        cmd.mul_sel  = MUL_NEW;
        cmd.acc_init = 1'b1;
      end
      ST_B1B: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_OLD;
        cmd.acc_add = 1'b1;
      end
      ST_B1C: cmd.acc_add = 1'b1;
      ST_B1D: cmd.smooth_load = 1'b1;
      ST_B2A: begin
        cmd.mul_go   = 1'b1;
        cmd.mul_sel  = MUL_NEW;
        cmd.w_beta   = 1'b1;
        cmd.acc_init = 1'b1;
      end
      ST_B2B: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_OLD;
        cmd.w_beta  = 1'b1;
        cmd.acc_add = 1'b1;
      end
      ST_B2C: cmd.acc_add = 1'b1;
      ST_B2D: begin
        cmd.drift_load = 1'b1;
        cmd.sync_done  = 1'b1;
      end
      ST_IV_LD: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DIV_IVAL;
      end
      ST_IV_DIV: cmd.div_step = 1'b1;
      ST_IV_END: cmd.iv_load = 1'b1;
      ST_EMIT:   cmd.out_load = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/pde_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module pde_dp (
  input  wire                  clk,
  input  wire                  rst,
  input  pde_pkg::dp_cmd_t     cmd,
  output pde_pkg::dp_status_t  status,
  input  wire  [7:0]           pulses_per_sync,
  input  wire  [23:0]          source_period_us,
  input  wire  [23:0]          flip_half_period_us,
  input  wire  [16:0]          alpha_q16,
  input  wire  [16:0]          beta_q16,
  input  wire  [31:0]          in_time,
  input  wire                  in_kind,
  input  wire                  out_ready,
  output logic                 out_valid,
  output logic [63:0]          out_data,
  output logic                 out_user
);
  import pde_pkg::*;

  // item and persistent state
  logic                   kind;
  logic [31:0]            now;
  logic [7:0]             pulse_phase;
  logic [31:0]            last_local_time;
  logic [31:0]            smoothed_drift;
  logic [31:0]            drift_estimate;
  logic [TIMER_WIDTH-1:0] toggle_interval;
  logic [TIMER_WIDTH-1:0] tick_count;
  logic                   led_state;
  logic                   synced;

  // working registers
  logic [31:0]            den;
  logic [31:0]            divisor;
  logic [DIV_W-1:0]       dq;
  logic [31:0]            rem;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [31:0]            inst;
  logic [PROD_W-1:0]      prod;
  logic [ACC_W-1:0]       acc;

  logic [8:0]             phase_inc;
  logic [TIMER_WIDTH-1:0] tick_inc;
  logic [32:0]            trial;
  logic [31:0]            elapsed;
  logic [DIV_W-1:0]       dividend;
  logic [16:0]            w_raw;
  logic [16:0]            w_clip;
  logic [31:0]            mul_x;
  logic [16:0]            mul_w;
  logic [31:0]            blend_res;
  logic [TIMER_WIDTH-1:0] iv_res;

  assign phase_inc = {1'b0, pulse_phase} + 9'd1;
  assign tick_inc  = tick_count + TIMER_WIDTH'(1);
  assign elapsed   = now - last_local_time;
  assign trial     = {rem, dq[DIV_W-1]} - {1'b0, divisor};

  always_comb begin
    if (cmd.div_src == DIV_INST) begin
      dividend = (DIV_W'(elapsed) << DRIFT_FRAC_BITS) + DIV_W'(den[31:1]);
    end else begin
      dividend = (DIV_W'(flip_half_period_us) << DRIFT_FRAC_BITS)
               + DIV_W'(drift_estimate[31:1]);
    end
  end

  // Q1.16 weight, anything above 1.0 counts as 1.0
  assign w_raw  = cmd.w_beta ? beta_q16 : alpha_q16;
  assign w_clip = (w_raw > W_FULL) ? W_FULL : w_raw;
  assign mul_x  = (cmd.mul_sel == MUL_NEW) ? inst : smoothed_drift;
  assign mul_w  = (cmd.mul_sel == MUL_NEW) ? w_clip : (W_FULL - w_clip);

  assign blend_res = (|acc[ACC_W-1:48]) ? 32'hFFFF_FFFF : acc[47:16];

  always_comb begin
    if (drift_estimate == 32'd0 || dq > DIV_W'(TIMER_MAX)) begin
      iv_res = TIMER_MAX;
    end else if (dq == '0) begin
      iv_res = TIMER_WIDTH'(1);
    end else begin
      iv_res = dq[TIMER_WIDTH-1:0];
    end
  end

  assign status.is_tick          = (kind == KIND_TICK);
  assign status.sync             = (phase_inc >= {1'b0, pulses_per_sync});
  assign status.first_after_sync = (pulse_phase == 8'd0);
  assign status.div_last         = (div_cnt == '0);
  assign status.out_free         = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_phase     <= '0;
      last_local_time <= '0;
      smoothed_drift  <= DRIFT_ONE;
      drift_estimate  <= DRIFT_ONE;
      toggle_interval <= RST_INTERVAL;
      tick_count      <= '0;
      led_state       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.tick_step) begin
        if (tick_inc >= toggle_interval) begin
          led_state  <= !led_state;
          tick_count <= '0;
        end else begin
          tick_count <= tick_inc;
        end
      end
      if (cmd.phase_adv) pulse_phase <= phase_inc[7:0];
      if (cmd.sync_done) begin
        pulse_phase     <= '0;
        last_local_time <= now;
      end
      if (cmd.smooth_load) smoothed_drift <= blend_res;
      if (cmd.drift_load)  drift_estimate <= blend_res;
      if (cmd.iv_load) begin
        // timer restart on the pulse after a sync
        toggle_interval <= iv_res;
        tick_count      <= '0;
        led_state       <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind   <= in_kind;
      now    <= in_time;
      synced <= 1'b0;
    end
    if (cmd.sync_done) synced <= 1'b1;
    if (cmd.den_mul) den <= 32'(pulses_per_sync) * 32'(source_period_us);
    if (cmd.div_load) begin
      dq      <= dividend;
      rem     <= '0;
      div_cnt <= DIV_CNT_W'(DIV_W - 1);
      divisor <= (cmd.div_src == DIV_INST) ? den : drift_estimate;
    end else if (cmd.div_step) begin
      // restoring division, one quotient bit a cycle
      if (!trial[32]) begin
        rem <= trial[31:0];
      end else begin
        rem <= {rem[30:0], dq[DIV_W-1]};
      end
      dq      <= {dq[DIV_W-2:0], !trial[32]};
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
    if (cmd.inst_load) begin
      if (den == 32'd0 || (|dq[DIV_W-1:32])) begin
        inst <= 32'hFFFF_FFFF;
      end else begin
        inst <= dq[31:0];
      end
    end
    if (cmd.mul_go) prod <= PROD_W'(mul_x) * PROD_W'(mul_w);
    if (cmd.acc_init) begin
      acc <= ROUND_HALF;
    end else if (cmd.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.out_load) begin
      out_data <= {7'd0, toggle_interval[FLIP_W-1:0], drift_estimate, led_state};
      out_user <= synced;
    end
  end

endmodule
`default_nettype wire

### rtl/pps_drift_estimator_blinker.sv
// PPS-disciplined LED blinker with drift estimate.
// Input stream: s_tdata carries the local microsecond time of a PPS falling
// edge, s_tuser the item kind (0 = PPS edge, 1 = microsecond tick).
// Output stream: one transaction per input item with the LED level, the
// current drift (unsigned Q2.30) and the corrected toggle interval;
// m_tuser is high when that item updated the drift.
// Registers sit on an APB port: pulses per sync, source period, nominal
// half period, alpha and beta weights (Q1.16). Write only while idle.
// Timing: an input is taken in the idle state; a tick or an ordinary pulse
// passes through the decide and emit states before its result is registered.
// The drift update on a sync pulse and the interval recompute on the pulse
// after it both run through the 64-step serial divider; the two blends share
// one 32x17 multiplier. Items are processed one at a time.
// A finished result waits in the output register while the next item is
// taken; if the receiver stalls, the block holds its next result until the
// register drains. Reset (synchronous) restores the register defaults,
// drift 1.0, interval 500000 us and LED low; no output is pending after it.
`timescale 1ns / 1ps
`default_nettype none
module pps_drift_estimator_blinker (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // [31:0] local_time_us
  input  wire         s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [63:0] m_tdata,   // [0] led_level, [32:1] drift_q30, [56:33] flip_period_us
  output logic        m_tuser,   // [0] sync_updated
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pde_pkg::*;

  logic [7:0]  pulses_per_sync;
  logic [23:0] source_period_us;
  logic [23:0] flip_half_period_us;
  logic [16:0] alpha_q16;
  logic [16:0] beta_q16;
  logic [2:0]  reg_idx;
  logic        wr_en;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulses_per_sync     <= RST_PULSES_PER_SYNC;
      source_period_us    <= RST_SOURCE_PERIOD;
      flip_half_period_us <= RST_FLIP_HALF;
      alpha_q16           <= RST_ALPHA;
      beta_q16            <= RST_BETA;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PULSES_PER_SYNC: pulses_per_sync     <= pwdata[7:0];
        REG_SOURCE_PERIOD:   source_period_us    <= pwdata[23:0];
        REG_FLIP_HALF:       flip_half_period_us <= pwdata[23:0];
        REG_ALPHA:           alpha_q16           <= pwdata[16:0];
        REG_BETA:            beta_q16            <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PULSES_PER_SYNC: prdata = {24'd0, pulses_per_sync};
      REG_SOURCE_PERIOD:   prdata = {8'd0, source_period_us};
      REG_FLIP_HALF:       prdata = {8'd0, flip_half_period_us};
      REG_ALPHA:           prdata = {15'd0, alpha_q16};
      REG_BETA:            prdata = {15'd0, beta_q16};
      default:             prdata = 32'd0;
    endcase
  end

  pde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pde_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .pulses_per_sync     (pulses_per_sync),
    .source_period_us    (source_period_us),
    .flip_half_period_us (flip_half_period_us),
    .alpha_q16           (alpha_q16),
    .beta_q16            (beta_q16),
    .in_time             (s_tdata),
    .in_kind             (s_tuser),
    .out_ready           (m_tready),
    .out_valid           (m_tvalid),
    .out_data            (m_tdata),
    .out_user            (m_tuser)
  );

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import pde_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [31:0] stamp;
  } pps_item_t;

  typedef struct packed {
    logic        led;
    logic [31:0] drift;
    logic [23:0] period;
    logic        synced;
  } blink_status_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

  localparam logic [63:0] Q16_ONE  = 64'd65536;
  localparam logic [63:0] TMR_LIMIT = 64'(TIMER_MAX);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] local_time_us
  logic        s_tuser = 1'b0; // [0] kind
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [63:0] m_tdata;        // [0] led_level, [32:1] drift_q30, [56:33] flip_period_us
  wire         m_tuser;        // [0] sync_updated
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  pps_drift_estimator_blinker u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // blinker model: registers and state
  logic [7:0]  cfg_pulses;
  logic [23:0] cfg_period;
  logic [23:0] cfg_half;
  logic [16:0] cfg_alpha;
  logic [16:0] cfg_beta;
  logic [7:0]  mdl_phase;
  logic [31:0] mdl_last;
  logic [31:0] mdl_smooth;
  logic [31:0] mdl_drift;
  logic [23:0] mdl_interval;
  logic [31:0] mdl_ticks;
  logic        mdl_led;

  pps_item_t     pps_tick_q[$];
  blink_status_t due_status_q[$];

  int n_errors = 0;
  int n_results = 0;
  int n_syncs = 0;
  int n_restarts = 0;
  int n_toggles = 0;
  int n_settings = 1;

  function automatic logic [31:0] clip32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // w * a + (1 - w) * b, Q1.16 weight, rounded half up
  function automatic logic [31:0] weigh(input logic [31:0] a, input logic [31:0] b,
                                        input logic [16:0] w);
    logic [63:0] wc;
    logic [63:0] acc;
    wc = (64'(w) > Q16_ONE) ? Q16_ONE : 64'(w);
    acc = 64'(a) * wc + 64'(b) * (Q16_ONE - wc) + 64'd32768;
    return clip32(acc >> 16);
  endfunction

  function automatic logic [23:0] toggle_from_drift();
    logic [63:0] q;
    if (mdl_drift == 32'd0) begin
      q = TMR_LIMIT;
    end else begin
      q = ((64'(cfg_half) << DRIFT_FRAC_BITS) + 64'(mdl_drift >> 1)) / 64'(mdl_drift);
    end
    if (q < 64'd1) q = 64'd1;
    if (q > TMR_LIMIT) q = TMR_LIMIT;
    return q[23:0];
  endfunction

  function automatic blink_status_t advance_blinker(input logic kind, input logic [31:0] stamp);
    blink_status_t st;
    logic [8:0]  p;
    logic [31:0] elapsed;
    logic [63:0] den;
    logic [31:0] inst;
    st.synced = 1'b0;
    if (kind == KIND_PPS) begin
      p = {1'b0, mdl_phase} + 9'd1;
      if (p >= {1'b0, cfg_pulses}) begin
        elapsed = stamp - mdl_last;
        den = 64'(cfg_pulses) * 64'(cfg_period);
        if (den == 64'd0) begin
          inst = '1;
        end else begin
          inst = clip32(((64'(elapsed) << DRIFT_FRAC_BITS) + (den >> 1)) / den);
        end
        mdl_smooth = weigh(inst, mdl_smooth, cfg_alpha);
        mdl_drift  = weigh(inst, mdl_smooth, cfg_beta);
        mdl_last   = stamp;
        mdl_phase  = 8'd0;
        st.synced  = 1'b1;
        n_syncs++;
      end else begin
        if (p == 9'd1) begin
          mdl_led = 1'b0;
          mdl_ticks = '0;
          mdl_interval = toggle_from_drift();
          n_restarts++;
        end
        mdl_phase = p[7:0];
      end
    end else begin
      mdl_ticks = mdl_ticks + 32'd1;
      if (mdl_ticks >= {8'd0, mdl_interval}) begin
        mdl_led = ~mdl_led;
        mdl_ticks = '0;
        n_toggles++;
      end
    end
    st.led = mdl_led;
    st.drift = mdl_drift;
    st.period = mdl_interval;
    return st;
  endfunction

  task automatic reset_blinker_model();
    cfg_pulses = 8'd10;
    cfg_period = 24'd1000000;
    cfg_half = 24'd500000;
    cfg_alpha = 17'd19661;
    cfg_beta = 17'd13107;
    mdl_phase = '0;
    mdl_last = '0;
    mdl_smooth = 32'd1 << DRIFT_FRAC_BITS;
    mdl_drift = 32'd1 << DRIFT_FRAC_BITS;
    mdl_interval = 24'd500000;
    mdl_ticks = '0;
    mdl_led = 1'b0;
  endtask

  // driver: bursts of transactions separated by random gaps
  bit        in_fire = 1'b0;
  int        gap_left = 0;
  int        burst_left = 1;
  pps_item_t drv_item;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pps_tick_q.size() > 0) begin
        drv_item = pps_tick_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= drv_item.kind;
        s_tdata <= drv_item.stamp;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure, switching between patterns
  rx_mode_t   rx_mode = RX_FREE;
  int         rx_left = 0;
  logic [7:0] rx_cnt = '0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cnt <= rx_cnt + 8'd1;
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(20, 300);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_FREE:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= (rx_cnt[3:0] == 4'd0);
        default:   m_tready <= (rx_cnt[5:0] >= 6'd40);
      endcase
    end
  end

  // monitor and scoreboard
  blink_status_t want;

  always @(posedge clk) begin
    if (rst) begin
      in_fire = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (due_status_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          n_errors++;
        end else begin
          want = due_status_q.pop_front();
          if (m_tdata[0] !== want.led) begin
            $error("led_level: expected %0d, got %0d", want.led, m_tdata[0]);
            n_errors++;
          end
          if (m_tdata[32:1] !== want.drift) begin
            $error("drift_q30: expected %h, got %h", want.drift, m_tdata[32:1]);
            n_errors++;
          end
          if (m_tdata[56:33] !== want.period) begin
            $error("flip_period_us: expected %0d, got %0d", want.period, m_tdata[56:33]);
            n_errors++;
          end
          if (m_tuser !== want.synced) begin
            $error("sync_updated: expected %0d, got %0d", want.synced, m_tuser);
            n_errors++;
          end
        end
      end
      in_fire = s_tvalid && s_tready;
      if (in_fire) due_status_q.push_back(advance_blinker(s_tuser, s_tdata));
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PULSES_PER_SYNC: cfg_pulses = val[7:0];
      REG_SOURCE_PERIOD:   cfg_period = val[23:0];
      REG_FLIP_HALF:       cfg_half = val[23:0];
      REG_ALPHA:           cfg_alpha = val[16:0];
      REG_BETA:            cfg_beta = val[16:0];
      default: ;
    endcase
  endtask

  task automatic set_blinker(input logic [7:0] pulses, input logic [23:0] period,
                             input logic [23:0] half, input logic [16:0] alpha,
                             input logic [16:0] beta);
    cfg_write(REG_PULSES_PER_SYNC, 32'(pulses));
    cfg_write(REG_SOURCE_PERIOD, 32'(period));
    cfg_write(REG_FLIP_HALF, 32'(half));
    cfg_write(REG_ALPHA, 32'(alpha));
    cfg_write(REG_BETA, 32'(beta));
    n_settings++;
  endtask

  task automatic queue_item(input logic kind, input logic [31:0] stamp);
    pps_item_t it;
    it.kind = kind;
    it.stamp = stamp;
    pps_tick_q.push_back(it);
  endtask

  // sender holds off until every expected result is back
  task automatic await_quiet();
    do @(posedge clk); while (pps_tick_q.size() != 0 || s_tvalid || due_status_q.size() != 0);
  endtask

  // mostly regular PPS trains around the source period with ticks between,
  // plus stray pulses and loose tick runs
  task automatic gen_sequences(input int n, output int made);
    logic [31:0] ts;
    int k;
    int span;
    ts = mdl_last;
    made = 0;
    span = (cfg_half < 24'd16) ? 3 * int'(cfg_half) + 2 : 48;
    while (made < n) begin
      case ($urandom_range(0, 19))
        0: begin
          queue_item(KIND_PPS, $urandom());
          made++;
        end
        1: begin
          k = $urandom_range(1, 8);
          repeat (k) queue_item(KIND_TICK, $urandom());
          made += k;
        end
        default: begin
          k = $urandom_range(0, span);
          repeat (k) queue_item(KIND_TICK, $urandom());
          ts = ts + 32'(cfg_period) + $urandom_range(0, int'(cfg_period / 32) + 2)
               - (32'(cfg_period / 64) + 32'd1);
          queue_item(KIND_PPS, ts);
          made += k + 1;
        end
      endcase
    end
  endtask

  function automatic logic [16:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return 17'h10000;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    logic [7:0]  r_pulses;
    logic [23:0] r_period;
    logic [23:0] r_half;
    int made;
    int n_random;
    reset_blinker_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: ignored tick field, first pulses after reset
    queue_item(KIND_TICK, 32'd0);
    queue_item(KIND_TICK, 32'hFFFF_FFFF);
    for (int k = 0; k < 5; k++) queue_item(KIND_PPS, 32'(k * 1000000));
    await_quiet();

    // count lowered below the phase: next pulse syncs (first update, prev stamp 0)
    cfg_write(REG_PULSES_PER_SYNC, 32'd3);
    n_settings++;
    queue_item(KIND_PPS, 32'hFFFF_FFFF);
    queue_item(KIND_PPS, 32'd0);
    repeat (3) queue_item(KIND_TICK, $urandom());
    await_quiet();

    // one pulse per sync, extreme period, weights at their ends
    set_blinker(8'd1, 24'hFFFFFF, 24'd1, 17'd0, 17'h10000);
    queue_item(KIND_PPS, $urandom());
    queue_item(KIND_TICK, $urandom());
    queue_item(KIND_PPS, $urandom());
    queue_item(KIND_TICK, $urandom());
    await_quiet();

    // zero count and zero period: divisor zero; oversized alpha
    set_blinker(8'd0, 24'd0, 24'd1, 17'h1FFFF, 17'd0);
    queue_item(KIND_PPS, $urandom());
    queue_item(KIND_PPS, $urandom());
    await_quiet();

    // zero elapsed time drives drift to zero, then interval saturates
    set_blinker(8'd2, 24'd1, 24'hFFFFFF, 17'h10000, 17'h10000);
    queue_item(KIND_PPS, mdl_last);
    queue_item(KIND_PPS, mdl_last);
    queue_item(KIND_PPS, $urandom());
    queue_item(KIND_TICK, $urandom());
    await_quiet();

    // zero half period clamps the interval to one tick
    set_blinker(8'd2, 24'd1, 24'd0, 17'd1, 17'hFFFF);
    queue_item(KIND_PPS, mdl_last + 32'd5);
    queue_item(KIND_PPS, $urandom());
    repeat (3) queue_item(KIND_TICK, $urandom());
    await_quiet();

    n_random = 0;
    while (n_random < 2000) begin
      case ($urandom_range(0, 9))
        0: r_pulses = 8'd0;
        1: r_pulses = 8'd1;
        2: r_pulses = 8'd255;
        default: r_pulses = 8'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 9))
        0: r_period = 24'd0;
        1: r_period = 24'hFFFFFF;
        2: r_period = 24'($urandom());
        default: r_period = 24'($urandom_range(1, 200));
      endcase
      case ($urandom_range(0, 9))
        0: r_half = 24'd0;
        1: r_half = 24'hFFFFFF;
        2: r_half = 24'($urandom());
        default: r_half = 24'($urandom_range(1, 40));
      endcase
      set_blinker(r_pulses, r_period, r_half, pick_weight(), pick_weight());
      gen_sequences($urandom_range(100, 220), made);
      n_random += made;
      await_quiet();
    end

    repeat (100) @(posedge clk);
    if (due_status_q.size() != 0) begin
      $error("%0d expected results never arrived", due_status_q.size());
      n_errors++;
    end
    $display("Checked %0d result transactions over %0d register settings.",
             n_results, n_settings);
    $display("Model saw %0d drift updates, %0d timer restarts, %0d LED toggles.",
             n_syncs, n_restarts, n_toggles);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("Timeout: block stopped responding");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### pps_drift_estimator_blinker.f
rtl/pde_pkg.sv
rtl/pde_ctrl.sv
rtl/pde_dp.sv
rtl/pps_drift_estimator_blinker.sv
tb/testbench.sv
